[sv/assert_macros.svh]
// Shared assertion macros; clk and rst are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SSPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/sspf_pkg.sv]
package sspf_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] ID_RESET    = 8'h01;
  localparam int         NUM_PARAMS  = 8;
  localparam logic [3:0] IDX_SAT     = 4'd9;

  typedef enum logic [1:0] {
    KIND_MEAS  = 2'd0,
    KIND_OTHER = 2'd1,
    KIND_BAD   = 2'd2
  } frame_kind_t;

endpackage

[sv/servo_status_frame_parser_unit.sv]
// Servo status frame parser. Takes one bus byte per request and follows frames
// FF FF, id, length, body; after a batch start it hunts for the first FF FF pair
// and then expects frames back to back. One result request leaves per finished
// frame (measurement when the id matches cfg_data's stored id, unrecognized
// otherwise) and one per broken header. A byte is taken every cycle while the
// result register is empty or being drained, so throughput is one byte per
// clock; the result of a frame shows on the output the cycle after its last
// byte is accepted. The id register may only be written while no frame is
// being delivered.
module servo_status_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        batch_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_kind,
  output logic [7:0]  servo_id,
  output logic [7:0]  servo_status,
  output logic [15:0] position,
  output logic [15:0] speed,
  output logic [15:0] load,
  output logic [7:0]  voltage,
  output logic [7:0]  temperature
);

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic        prev_ff, prev_ff_next;
  logic        synced, synced_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [3:0]  param_index, param_index_next;
  logic [7:0]  cap_status, cap_status_next;
  logic [7:0]  params [sspf_pkg::NUM_PARAMS];
  logic [7:0]  params_next [sspf_pkg::NUM_PARAMS];
  logic [7:0]  expected_id;

  logic        accept;
  logic        is_ff;
  logic        emit_frame;
  logic        emit_bad;
  logic [2:0]  slot;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_ff     = (rx_byte == sspf_pkg::HDR_BYTE);
  assign slot      = param_index[2:0] - 3'd1;

  always_comb begin
    phase_next       = phase;
    prev_ff_next     = prev_ff;
    synced_next      = synced;
    frame_id_next    = frame_id;
    bytes_left_next  = bytes_left;
    param_index_next = param_index;
    cap_status_next  = cap_status;
    params_next      = params;
    emit_frame       = 1'b0;
    emit_bad         = 1'b0;
    if (!synced || batch_start) begin
      synced_next  = prev_ff && !batch_start && is_ff;
      phase_next   = (prev_ff && !batch_start && is_ff) ? PH_ID : PH_HDR1;
      prev_ff_next = is_ff;
    end else begin
      case (phase)
        PH_HDR1: begin
          if (!is_ff) emit_bad = 1'b1;
          else phase_next = PH_HDR2;
        end
        PH_HDR2: begin
          if (!is_ff) emit_bad = 1'b1;
          else phase_next = PH_ID;
        end
        PH_ID: begin
          frame_id_next    = rx_byte;
          cap_status_next  = 8'd0;
          for (int i = 0; i < sspf_pkg::NUM_PARAMS; i++) params_next[i] = 8'd0;
          param_index_next = 4'd0;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          bytes_left_next = rx_byte;
          if (rx_byte == 8'd0) begin
            emit_frame = 1'b1;
            phase_next = PH_HDR1;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          if (bytes_left <= 8'd1) begin
            bytes_left_next = 8'd0;
            emit_frame      = 1'b1;
            phase_next      = PH_HDR1;
          end else begin
            if (param_index == 4'd0) cap_status_next = rx_byte;
            else if (param_index <= 4'd8) params_next[slot] = rx_byte;
            if (param_index < sspf_pkg::IDX_SAT) param_index_next = param_index + 4'd1;
            bytes_left_next = bytes_left - 8'd1;
          end
        end
        default: begin
          phase_next   = PH_HDR1;
          synced_next  = 1'b0;
          prev_ff_next = is_ff;
        end
      endcase
      if (emit_bad) begin
        synced_next  = 1'b0;
        prev_ff_next = 1'b0;
        phase_next   = PH_HDR1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR1;
      prev_ff     <= 1'b0;
      synced      <= 1'b0;
      frame_id    <= 8'd0;
      bytes_left  <= 8'd0;
      param_index <= 4'd0;
      cap_status  <= 8'd0;
      for (int i = 0; i < sspf_pkg::NUM_PARAMS; i++) params[i] <= 8'd0;
      expected_id <= sspf_pkg::ID_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) expected_id <= cfg_data;
      if (accept && (emit_frame || emit_bad)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (accept) begin
        phase       <= phase_next;
        prev_ff     <= prev_ff_next;
        synced      <= synced_next;
        frame_id    <= frame_id_next;
        bytes_left  <= bytes_left_next;
        param_index <= param_index_next;
        cap_status  <= cap_status_next;
        params      <= params_next;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (accept && emit_bad) begin
      frame_kind   <= sspf_pkg::KIND_BAD;
      servo_id     <= 8'd0;
      servo_status <= 8'd0;
      position     <= 16'd0;
      speed        <= 16'd0;
      load         <= 16'd0;
      voltage      <= 8'd0;
      temperature  <= 8'd0;
    end else if (accept && emit_frame) begin
      servo_id <= frame_id;
      if (frame_id == expected_id) begin
        frame_kind   <= sspf_pkg::KIND_MEAS;
        servo_status <= cap_status;
        position     <= {params[1], params[0]};
        speed        <= {params[3], params[2]};
        load         <= {params[5], params[4]};
        voltage      <= params[6];
        temperature  <= params[7];
      end else begin
        frame_kind   <= sspf_pkg::KIND_OTHER;
        servo_status <= 8'd0;
        position     <= 16'd0;
        speed        <= 16'd0;
        load         <= 16'd0;
        voltage      <= 8'd0;
        temperature  <= 8'd0;
      end
    end
  end

endmodule

[sv/sspf_checker.sv]
`include "assert_macros.svh"

module sspf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        batch_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  frame_kind,
  input logic [7:0]  servo_id,
  input logic [7:0]  servo_status,
  input logic [15:0] position,
  input logic [15:0] speed,
  input logic [15:0] load,
  input logic [7:0]  voltage,
  input logic [7:0]  temperature
);

  logic meas_zero;
  logic bad_req;
  logic stalled;
  assign meas_zero = (servo_status == 8'd0) && (position == 16'd0) && (speed == 16'd0) &&
                     (load == 16'd0) && (voltage == 8'd0) && (temperature == 8'd0);
  assign bad_req   = out_valid && frame_kind == sspf_pkg::KIND_BAD;
  assign stalled   = out_valid && !out_ready;

  // bad header request carries nothing but its kind
  `SSPF_ASSERT_NOW(a_bad_zero, bad_req, servo_id == 8'd0 && meas_zero)
  // unrecognized id frame carries no measurement
  `SSPF_ASSERT_NOW(a_other_zero, out_valid && frame_kind == sspf_pkg::KIND_OTHER, meas_zero)
  // a batch start byte only restarts the hunt
  `SSPF_ASSERT_NEXT(a_batch_quiet, in_valid && in_ready && batch_start, !out_valid)
  // stalled result holds
  `SSPF_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(frame_kind) && $stable(servo_id))

endmodule

bind servo_status_frame_parser_unit sspf_checker u_sspf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .batch_start  (batch_start),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_kind   (frame_kind),
  .servo_id     (servo_id),
  .servo_status (servo_status),
  .position     (position),
  .speed        (speed),
  .load         (load),
  .voltage      (voltage),
  .temperature  (temperature)
);

[bench/tb_servo_status_frame_parser_unit.sv]
module tb_servo_status_frame_parser_unit;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BYTES   = 65;
  localparam int NUM_PHASES    = 5;
  localparam int DIR_N         = 26;

  typedef enum logic [2:0] {PH_HDR1, PH_HDR2, PH_ID, PH_LEN, PH_BODY} parse_phase_t;

  typedef struct packed {
    sspf_pkg::frame_kind_t kind;
    logic [7:0]   id;
    logic [7:0]   status;
    logic [15:0]  pos;
    logic [15:0]  spd;
    logic [15:0]  ld;
    logic [7:0]   volt;
    logic [7:0]   temp;
  } frame_rep_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        typed;
    frame_rep_t  want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        batch_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_kind;
  logic [7:0]  servo_id;
  logic [7:0]  servo_status;
  logic [15:0] position;
  logic [15:0] speed;
  logic [15:0] load;
  logic [7:0]  voltage;
  logic [7:0]  temperature;

  // tag riding along with the byte request, for rows with a hand-written result
  logic        row_typed = 1'b0;
  frame_rep_t  row_want = '0;

  // parser state as the block should hold it
  parse_phase_t phase = PH_HDR1;
  logic         locked = 1'b0;
  logic         prev_hdr = 1'b0;
  logic [7:0]   fid = 8'h00;
  logic [7:0]   left = 8'h00;
  logic [3:0]   pidx = 4'd0;
  logic [7:0]   cstat = 8'h00;
  logic [7:0]   cparam [sspf_pkg::NUM_PARAMS] = '{default: 8'h00};
  logic [7:0]   want_id = sspf_pkg::ID_RESET;

  frame_rep_t frames_due [$];
  row_t       burst [$];
  int         errors = 0;
  int         cycle_count = 0;
  logic       steady = 1'b0;
  logic       long_hold = 1'b0;

  row_t directed_rows [DIR_N] = '{
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h0B, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h77, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b1,
      '{sspf_pkg::KIND_MEAS, 8'h01, 8'hA5, 16'hFFFF, 16'h0000, 16'h1234, 8'hFF, 8'h00}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1,
      '{sspf_pkg::KIND_OTHER, 8'h02, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h37, 1'b0, 1'b1,
      '{sspf_pkg::KIND_BAD, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b1,
      '{sspf_pkg::KIND_OTHER, 8'hFF, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00}}
  };

  servo_status_frame_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .batch_start  (batch_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_kind   (frame_kind),
    .servo_id     (servo_id),
    .servo_status (servo_status),
    .position     (position),
    .speed        (speed),
    .load         (load),
    .voltage      (voltage),
    .temperature  (temperature)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic bs,
                            output logic made, output frame_rep_t r);
    logic hdr;
    logic done;
    logic bad;
    hdr = (b == sspf_pkg::HDR_BYTE);
    done = 1'b0;
    bad = 1'b0;
    made = 1'b0;
    r = '0;
    if (bs) begin
      locked = 1'b0;
      prev_hdr = 1'b0;
      phase = PH_HDR1;
    end
    if (!locked) begin
      if (prev_hdr && hdr) begin
        locked = 1'b1;
        phase = PH_ID;
      end
      prev_hdr = hdr;
    end else begin
      case (phase)
        PH_HDR1: begin
          if (hdr) phase = PH_HDR2;
          else bad = 1'b1;
        end
        PH_HDR2: begin
          if (hdr) phase = PH_ID;
          else bad = 1'b1;
        end
        PH_ID: begin
          fid = b;
          cstat = 8'h00;
          cparam = '{default: 8'h00};
          pidx = 4'd0;
          phase = PH_LEN;
        end
        PH_LEN: begin
          left = b;
          if (left == 8'h00) done = 1'b1;
          else phase = PH_BODY;
        end
        default: begin
          if (left <= 8'd1) begin
            left = 8'h00;
            done = 1'b1;
          end else begin
            if (pidx == 4'd0) cstat = b;
            else if (pidx <= 4'd8) cparam[pidx - 4'd1] = b;
            if (pidx < sspf_pkg::IDX_SAT) pidx = pidx + 4'd1;
            left = left - 8'd1;
          end
        end
      endcase
    end
    if (bad) begin
      locked = 1'b0;
      prev_hdr = 1'b0;
      phase = PH_HDR1;
      made = 1'b1;
      r.kind = sspf_pkg::KIND_BAD;
    end
    if (done) begin
      phase = PH_HDR1;
      made = 1'b1;
      r.id = fid;
      if (fid == want_id) begin
        r.kind = sspf_pkg::KIND_MEAS;
        r.status = cstat;
        r.pos = {cparam[1], cparam[0]};
        r.spd = {cparam[3], cparam[2]};
        r.ld = {cparam[5], cparam[4]};
        r.volt = cparam[6];
        r.temp = cparam[7];
      end else begin
        r.kind = sspf_pkg::KIND_OTHER;
      end
    end
  endtask

  task automatic check_field(input string nm, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
    end
  endtask

  always @(posedge clk) begin
    logic made;
    frame_rep_t r;
    frame_rep_t e;
    if (!rst) begin
      if (in_valid && in_ready) begin
        parse_byte(rx_byte, batch_start, made, r);
        if (made) frames_due.push_back(row_typed ? row_want : r);
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, got kind %0d id %0h", $time,
                   frame_kind, servo_id);
        end else begin
          e = frames_due.pop_front();
          check_field("frame_kind", 16'(e.kind), 16'(frame_kind));
          check_field("servo_id", 16'(e.id), 16'(servo_id));
          check_field("servo_status", 16'(e.status), 16'(servo_status));
          check_field("position", e.pos, position);
          check_field("speed", e.spd, speed);
          check_field("load", e.ld, load);
          check_field("voltage", 16'(e.volt), 16'(voltage));
          check_field("temperature", 16'(e.temp), 16'(temperature));
        end
      end
    end
  end

  initial begin : result_sink
    int span;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else begin
        span = pick_gap();
        if (span == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (span) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic offer(input row_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= r.data;
    batch_start <= r.first;
    row_typed <= r.typed;
    row_want <= r.want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_id(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    want_id = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_frame(input logic [7:0] id, input int len);
    row_t r;
    r = '0;
    r.data = sspf_pkg::HDR_BYTE;
    burst.push_back(r);
    burst.push_back(r);
    r.data = id;
    burst.push_back(r);
    r.data = 8'(len);
    burst.push_back(r);
    repeat (len) begin
      r.data = 8'($urandom);
      burst.push_back(r);
    end
  endtask

  task automatic build_traffic(input int n_bytes, input logic with_long);
    int k;
    int len;
    int cut;
    row_t r;
    burst.delete();
    if (with_long) add_frame(want_id, 255);
    while (burst.size() < n_bytes) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        r = '0;
        r.data = 8'($urandom);
        r.first = 1'b1;
        burst.push_back(r);
      end else if (k < 14) begin
        // junk where a header should be
        repeat ($urandom_range(1, 3)) begin
          r = '0;
          r.data = 8'($urandom);
          burst.push_back(r);
        end
      end else begin
        len = (k < 95) ? $urandom_range(0, 11) : $urandom_range(12, 24);
        add_frame(($urandom_range(0, 1) == 1) ? want_id : 8'($urandom), len);
        if (k < 20) begin
          // frame cut short by a new batch
          cut = $urandom_range(1, len + 3);
          repeat (cut) void'(burst.pop_back());
          r = '0;
          r.data = 8'($urandom);
          r.first = 1'b1;
          burst.push_back(r);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) offer(directed_rows[i]);
    settle();
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_id(8'h00);
        1: write_id(8'hFF);
        default: write_id(8'($urandom));
      endcase
      if (p == 2) begin
        steady = 1'b1;
        long_hold = 1'b1;
      end
      build_traffic(PHASE_BYTES, p == 3);
      foreach (burst[i]) offer(burst[i]);
      settle();
      steady = 1'b0;
    end
    if (errors == 0 && frames_due.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[servo_status_frame_parser_unit.f]
+incdir+sv
sv/sspf_pkg.sv
sv/servo_status_frame_parser_unit.sv
sv/sspf_checker.sv
bench/tb_servo_status_frame_parser_unit.sv
